FILE: design/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the sharpen filter RTL.
// No dependencies; compiled ahead of the package and the modules that include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define SHRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define SHRP_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SHRP_ASSERT(lbl, clk, rstn, prop, msg)
`define SHRP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: design/shrp_pkg.sv
// shrp_pkg: types, register indexes and default sizes of the 3x3 sharpen filter.
// No dependencies; every module of the block imports it.
`default_nettype none
package shrp_pkg;

  localparam int DefMaxWidth      = 4096;
  localparam int DefCoeffFracBits = 8;
  localparam int WidthLimit       = 4096;
  localparam int HeightLimit      = 4096;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int DimW     = 13;
  localparam int WeightW  = 12;
  localparam int SumW     = 11;

  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NEIGHBOR_WEIGHT = 2'd2;

  localparam logic [DimW-1:0]    RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [DimW-1:0]    RST_IMAGE_HEIGHT    = 13'd480;
  localparam logic [WeightW-1:0] RST_NEIGHBOR_WEIGHT = 12'hF00;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Channel k sits at bits 8k+7:8k: red, green, blue, alpha.
  typedef logic [3:0][7:0] rgba_t;
  typedef logic [3:0][SumW-1:0] nsum_t;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } out_beat_t;

  // One line store entry: the pixel two rows up and the one a row up.
  typedef struct packed {
    rgba_t upper;
    rgba_t middle;
  } line_pair_t;

  // Per-item decisions made at accept time.
  typedef struct packed {
    logic emit;
    logic left_edge;
    logic right_edge;
    logic top_edge;
    logic bottom_edge;
    logic frame_end;
  } item_ctl_t;

endpackage
`default_nettype wire

FILE: design/sharpen_3x3_convolution.sv
// sharpen_3x3_convolution: top level of the 3x3 RGBA sharpen filter.
// Depends on shrp_pkg, assert_macros.svh, shrp_ctrl, shrp_line, shrp_window, shrp_mac.
//
//   channel | ports                                  | beat
//   --------+----------------------------------------+-------------------------------
//   input   | in_valid_i, in_stall_o, in_data_i      | one pixel or flush tick
//   output  | out_valid_o, out_stall_i, out_data_o   | one filtered pixel
//   config  | cfg_we_i, cfg_idx_i, cfg_data_i        | one register write, no wait
//
// Throughput is one beat per cycle while the output is not stalled; the line store
// memory takes one read and one write each cycle. A result passes the line store
// read, window/sums, multiply and clamp stages before it leaves the output register.
// Reset clears counters, window and valid bits; the line store is not cleared.
// An output stall fills pipeline bubbles first, then stalls the input.
`default_nettype none
`include "assert_macros.svh"
module sharpen_3x3_convolution
  import shrp_pkg::*;
#(
  parameter int MAX_WIDTH       = DefMaxWidth,
  parameter int COEFF_FRAC_BITS = DefCoeffFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                      accept, live, blank;
  item_ctl_t                 ctl;
  logic [AW-1:0]             col;
  logic signed [WeightW-1:0] weight;
  rgba_t                     px_in;

  // Stage 1: beat plus its line store read.
  logic          s1_valid_q;
  item_ctl_t     s1_ctl_q;
  rgba_t         s1_px_q;
  logic [AW-1:0] s1_col_q;
  logic          s1_load, s1_fire, s1_free;
  line_pair_t    rd_pair, wr_pair;

  // Stage 2: neighbor sums. Stage 3: products. Then the output register.
  logic  s2_valid_q, s3_valid_q, out_valid_q;
  logic  s2_move, s3_move, s2_free, s3_free, out_ready;
  nsum_t nsum;
  rgba_t center;
  logic  frame_end;

  assign accept = in_valid_i && !in_stall_o;

  shrp_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .flush_i    (in_data_i.command),
    .live_o     (live),
    .blank_o    (blank),
    .ctl_o      (ctl),
    .col_o      (col),
    .weight_o   (weight)
  );

  // Drain beats after the frame is in carry a zero pixel.
  always_comb begin
    px_in[0] = in_data_i.red_in;
    px_in[1] = in_data_i.green_in;
    px_in[2] = in_data_i.blue_in;
    px_in[3] = in_data_i.alpha_in;
    if (blank) begin
      px_in = '0;
    end
  end

  // Handshake chain, back to front: a stage advances when the next one is free.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s3_move   = s3_valid_q && out_ready;
  assign s3_free   = !s3_valid_q || out_ready;
  assign s2_move   = s2_valid_q && s3_free;
  assign s2_free   = !s2_valid_q || s3_free;
  // A beat that emits nothing only shifts the window and writes back.
  assign s1_fire   = s1_valid_q && (!s1_ctl_q.emit || s2_free);
  assign s1_free   = !s1_valid_q || s1_fire;
  assign in_stall_o = !s1_free;
  assign s1_load   = accept && live;

  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_px_q;

  shrp_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_load),
    .rd_addr_i (col),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_pair),
    .rd_data_o (rd_pair)
  );

  shrp_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_fire),
    .ctl_i       (s1_ctl_q),
    .top_i       (rd_pair.upper),
    .mid_i       (rd_pair.middle),
    .px_i        (s1_px_q),
    .nsum_o      (nsum),
    .center_o    (center),
    .frame_end_o (frame_end)
  );

  shrp_mac #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .weight_i    (weight),
    .prod_en_i   (s2_move),
    .out_en_i    (s3_move),
    .nsum_i      (nsum),
    .center_i    (center),
    .frame_end_i (frame_end),
    .out_o       (out_data_o)
  );

  // Stage 1 payload: hold until the beat moves on.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_ctl_q <= ctl;
      s1_px_q  <= px_in;
      s1_col_q <= col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_ctl_q.emit) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_move) begin
        s3_valid_q <= 1'b1;
      end else if (s3_move) begin
        s3_valid_q <= 1'b0;
      end
      if (s3_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `SHRP_ASSERT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_col_q), "stage one beat lost while blocked")
  `SHRP_ASSERT(a_s1_silent, clk_i, rst_ni, s1_valid_q && !s1_ctl_q.emit |-> s1_fire, "non-emitting beat blocked")
  `SHRP_ASSERT(a_no_repeat, clk_i, rst_ni, out_valid_q && !out_stall_i && !s3_valid_q |=> !out_valid_q, "result delivered twice")

endmodule
`default_nettype wire

FILE: design/shrp_ctrl.sv
// shrp_ctrl: configuration registers and raster position counters.
// Depends on shrp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module shrp_ctrl
  import shrp_pkg::*;
#(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      accept_i,
  input  logic                      flush_i,
  output logic                      live_o,
  output logic                      blank_o,
  output item_ctl_t                 ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output logic signed [WeightW-1:0] weight_o
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int EW   = AW + 1;
  localparam int WLim = (MAX_WIDTH < WidthLimit) ? MAX_WIDTH : WidthLimit;

  logic [DimW-1:0]    width_q, height_q;
  logic [WeightW-1:0] weight_q;
  logic [AW-1:0]      in_col_q, in_col_d, out_col_q, out_col_d;
  logic [DimW-1:0]    in_row_q, in_row_d;
  logic [DimW-2:0]    out_row_q, out_row_d;

  logic [31:0]     width_ext;
  logic [EW-1:0]   eff_w, in_col_nx, out_col_nx;
  logic [DimW-1:0] eff_h, out_row_nx;
  logic            complete, started, in_col_last, out_col_last, row_last, frame_end;

  assign width_ext = 32'(width_q);

  always_comb begin
    priority if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (width_ext > WLim) begin
      eff_w = EW'(WLim);
    end else begin
      eff_w = width_ext[EW-1:0];
    end
    priority if (height_q == '0) begin
      eff_h = DimW'(1);
    end else if (height_q > DimW'(HeightLimit)) begin
      eff_h = DimW'(HeightLimit);
    end else begin
      eff_h = height_q;
    end
  end

  assign in_col_nx    = {1'b0, in_col_q} + EW'(1);
  assign out_col_nx   = {1'b0, out_col_q} + EW'(1);
  assign out_row_nx   = {1'b0, out_row_q} + DimW'(1);
  assign in_col_last  = in_col_nx >= eff_w;
  assign out_col_last = out_col_nx >= eff_w;
  assign row_last     = out_row_nx >= eff_h;

  assign complete  = in_row_q >= eff_h;
  assign started   = (in_row_q >= DimW'(2)) || (in_row_q == DimW'(1) && in_col_q != '0);
  assign frame_end = started && out_col_last && row_last;

  // Flush before the frame is in: drop. Pixel or flush after the frame is in: drain as zero.
  assign live_o  = !(flush_i == CMD_FLUSH && !complete);
  assign blank_o = complete;
  assign col_o   = in_col_q;
  assign weight_o = $signed(weight_q);

  // A pixel landing in column zero finishes the previous row: right edge forced.
  always_comb begin
    ctl_o.emit        = started;
    ctl_o.left_edge   = out_col_q == '0;
    ctl_o.right_edge  = out_col_last || (in_col_q == '0);
    ctl_o.top_edge    = out_row_q == '0;
    ctl_o.bottom_edge = row_last;
    ctl_o.frame_end   = frame_end;
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    priority if (cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept_i && live_o) begin
      if (frame_end) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (started) begin
          if (out_col_last) begin
            out_col_d = '0;
            out_row_d = out_row_nx[DimW-2:0];
          end else begin
            out_col_d = out_col_nx[AW-1:0];
          end
        end
        if (in_col_last) begin
          in_col_d = '0;
          in_row_d = in_row_q + DimW'(1);
        end else begin
          in_col_d = in_col_nx[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_IMAGE_WIDTH;
      height_q  <= RST_IMAGE_HEIGHT;
      weight_q  <= RST_NEIGHBOR_WEIGHT;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IMAGE_WIDTH:     width_q  <= cfg_data_i;
          REG_IMAGE_HEIGHT:    height_q <= cfg_data_i;
          REG_NEIGHBOR_WEIGHT: weight_q <= cfg_data_i[WeightW-1:0];
          default: ;
        endcase
      end
    end
  end

  `SHRP_NEVER(a_in_col_range, clk_i, rst_ni, {1'b0, in_col_q} >= eff_w, "input column past row end")
  `SHRP_NEVER(a_out_row_range, clk_i, rst_ni, {1'b0, out_row_q} >= eff_h, "output row past frame")
  `SHRP_ASSERT(a_frame_restart, clk_i, rst_ni, accept_i && live_o && ctl_o.frame_end |=> in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0, "counters not cleared after frame end")

endmodule
`default_nettype wire

FILE: design/shrp_line.sv
// shrp_line: the two line stores as one memory of pixel pairs, read at accept,
// written back as stage one fires; same-address forwarding. Depends on shrp_pkg.
`default_nettype none
module shrp_line
  import shrp_pkg::*;
#(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  line_pair_t                   wr_data_i,
  output line_pair_t                   rd_data_o
);

  line_pair_t mem [MAX_WIDTH];
  line_pair_t ram_q, fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      ram_q      <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Take the write of the same edge when it hits the address being read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : ram_q;

endmodule
`default_nettype wire

FILE: design/shrp_window.sv
// shrp_window: 3x3 pixel window, edge replication and neighbor sums per channel.
// Depends on shrp_pkg.
`default_nettype none
module shrp_window
  import shrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  item_ctl_t ctl_i,
  input  rgba_t     top_i,
  input  rgba_t     mid_i,
  input  rgba_t     px_i,
  output nsum_t     nsum_o,
  output rgba_t     center_o,
  output logic      frame_end_o
);

  rgba_t [2:0][2:0] win_q, win_d, tap;
  logic  [2:0][1:0] rs, cs;
  nsum_t sum_d, sum_q;
  rgba_t center_q;
  logic  frame_end_q;

  // Advance one column: row 0 from two lines up, row 2 is the new pixel.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = top_i;
    win_d[1][2] = mid_i;
    win_d[2][2] = px_i;
  end

  always_comb begin
    rs[0] = ctl_i.top_edge    ? 2'd1 : 2'd0;
    rs[1] = 2'd1;
    rs[2] = ctl_i.bottom_edge ? 2'd1 : 2'd2;
    cs[0] = ctl_i.left_edge   ? 2'd1 : 2'd0;
    cs[1] = 2'd1;
    cs[2] = ctl_i.right_edge  ? 2'd1 : 2'd2;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap[r][c] = win_d[rs[r]][cs[c]];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_d[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1)) begin
            sum_d[k] = sum_d[k] + SumW'(tap[r][c][k]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i && ctl_i.emit) begin
      sum_q       <= sum_d;
      center_q    <= tap[1][1];
      frame_end_q <= ctl_i.frame_end;
    end
  end

  assign nsum_o      = sum_q;
  assign center_o    = center_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

FILE: design/shrp_mac.sv
// shrp_mac: weight multiply, round to nearest and clamp to 0..255 per channel.
// Depends on shrp_pkg.
`default_nettype none
module shrp_mac
  import shrp_pkg::*;
#(
  parameter int COEFF_FRAC_BITS = DefCoeffFracBits
) (
  input  logic                      clk_i,
  input  logic signed [WeightW-1:0] weight_i,
  input  logic                      prod_en_i,
  input  logic                      out_en_i,
  input  nsum_t                     nsum_i,
  input  rgba_t                     center_i,
  input  logic                      frame_end_i,
  output out_beat_t                 out_o
);

  localparam int F    = COEFF_FRAC_BITS;
  localparam int CWW  = ((F + 2 > 15) ? F + 2 : 15) + 1;
  localparam int NPW  = WeightW + SumW + 1;
  localparam int CPW  = CWW + 9;
  localparam int ACCW = ((NPW > CPW) ? NPW : CPW) + 2;
  localparam int MagW = ACCW - F;
  localparam logic signed [ACCW-1:0] RoundBias = ACCW'(1) << (F - 1);

  logic signed [CWW-1:0]  centre_w;
  logic signed [NPW-1:0]  nprod_q [4];
  logic signed [CPW-1:0]  cprod_q [4];
  logic signed [ACCW-1:0] acc [4];
  logic [MagW-1:0]        mag [4];
  rgba_t                  level;
  logic                   frame_end_q;
  out_beat_t              out_q;

  // Centre weight is one minus eight neighbor weights.
  assign centre_w = (CWW'(1) <<< F) - (CWW'(weight_i) <<< 3);

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      for (int k = 0; k < 4; k++) begin
        nprod_q[k] <= NPW'(weight_i) * NPW'($signed({1'b0, nsum_i[k]}));
        cprod_q[k] <= CPW'(centre_w) * CPW'($signed({1'b0, center_i[k]}));
      end
      frame_end_q <= frame_end_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = ACCW'(nprod_q[k]) + ACCW'(cprod_q[k]) + RoundBias;
      mag[k] = acc[k][ACCW-1:F];
      priority if (acc[k][ACCW-1]) begin
        level[k] = '0;
      end else if (|mag[k][MagW-1:8]) begin
        level[k] = 8'hFF;
      end else begin
        level[k] = mag[k][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en_i) begin
      out_q.red_out   <= level[0];
      out_q.green_out <= level[1];
      out_q.blue_out  <= level[2];
      out_q.alpha_out <= level[3];
      out_q.frame_end <= frame_end_q;
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

FILE: tb/sv/sharpen_scoreboard_pkg.sv
// sharpen_scoreboard_pkg: pixel predictor and result check for the 3x3 sharpen filter bench.
// Depends on shrp_pkg for beat types, register indexes, reset values and sizes.
package sharpen_scoreboard_pkg;
  import shrp_pkg::*;

  class sharpen_scoreboard;
    rgba_t                upper_row [DefMaxWidth];
    rgba_t                middle_row [DefMaxWidth];
    rgba_t                taps_window [9];
    int                   in_col;
    int                   in_row;
    int                   out_col;
    int                   out_row;
    logic [DimW-1:0]      width_reg;
    logic [DimW-1:0]      height_reg;
    logic [WeightW-1:0]   weight_reg;
    out_beat_t            expected_pixels [$];
    int                   errors;
    int                   beats_noted;
    int                   pixels_checked;
    int                   frames_seen;

    function void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void clear();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (taps_window[i]) taps_window[i] = '0;
      restart_frame();
      width_reg      = RST_IMAGE_WIDTH;
      height_reg     = RST_IMAGE_HEIGHT;
      weight_reg     = RST_NEIGHBOR_WEIGHT;
      expected_pixels.delete();
      errors         = 0;
      beats_noted    = 0;
      pixels_checked = 0;
      frames_seen    = 0;
    endfunction

    // Zero counts as one; anything past the limit is held at the limit.
    function int clamp_dim(logic [DimW-1:0] value, int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return int'(value);
    endfunction

    function int frame_width();
      return clamp_dim(width_reg, (WidthLimit < DefMaxWidth) ? WidthLimit : DefMaxWidth);
    endfunction

    function int frame_height();
      return clamp_dim(height_reg, HeightLimit);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = value;
          restart_frame();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = value;
          restart_frame();
        end
        REG_NEIGHBOR_WEIGHT: begin
          weight_reg = value[WeightW-1:0];
        end
        default: ;
      endcase
    endfunction

    // Filter the pixel at (out_col, out_row) from window columns lc, cc, rc,
    // replicating edge rows and columns.
    function out_beat_t sharpen_pixel(int lc, int cc, int rc, int w, int h);
      int        rowsel [3];
      int        colsel [3];
      rgba_t     taps [9];
      rgba_t     res;
      longint    wt;
      longint    centre_wt;
      longint    nsum;
      longint    acc;
      out_beat_t beat;
      rowsel[0] = (out_row == 0) ? 1 : 0;
      rowsel[1] = 1;
      rowsel[2] = (out_row + 1 >= h) ? 1 : 2;
      colsel[0] = (out_col == 0) ? cc : lc;
      colsel[1] = cc;
      colsel[2] = (out_col + 1 >= w) ? cc : rc;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          taps[i * 3 + j] = taps_window[rowsel[i] * 3 + colsel[j]];
      wt        = longint'($signed(weight_reg));
      centre_wt = (longint'(1) << DefCoeffFracBits) - 8 * wt;
      for (int k = 0; k < 4; k++) begin
        nsum = 0;
        for (int i = 0; i < 9; i++)
          if (i != 4) nsum += longint'(taps[i][k]);
        acc = wt * nsum + centre_wt * longint'(taps[4][k])
            + (longint'(1) << (DefCoeffFracBits - 1));
        if (acc < 0) res[k] = 8'd0;
        else if ((acc >>> DefCoeffFracBits) > 255) res[k] = 8'd255;
        else res[k] = 8'(acc >>> DefCoeffFracBits);
      end
      beat.red_out   = res[0];
      beat.green_out = res[1];
      beat.blue_out  = res[2];
      beat.alpha_out = res[3];
      beat.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
      return beat;
    endfunction

    // Advance the filter by one accepted input beat; queue the pixel it releases.
    function void accept_beat(in_beat_t beat);
      int        w;
      int        h;
      int        col;
      bit        complete;
      bit        started;
      bit        have;
      rgba_t     px;
      rgba_t     top;
      rgba_t     mid;
      out_beat_t res;
      w        = frame_width();
      h        = frame_height();
      complete = in_row >= h;
      col      = in_col;
      have     = 1'b0;
      beats_noted++;
      if (beat.command == CMD_FLUSH && !complete) return;
      px = '0;
      if (!complete) px = {beat.alpha_in, beat.blue_in, beat.green_in, beat.red_in};
      started = in_row >= 2 || (in_row == 1 && col >= 1);
      // Column 0: the last pixel of the previous row leaves before the shift.
      if (started && col == 0) begin
        res  = sharpen_pixel(1, 2, 2, w, h);
        have = 1'b1;
      end
      if (col >= DefMaxWidth) col = DefMaxWidth - 1;
      top             = upper_row[col];
      mid             = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = px;
      for (int i = 0; i < 3; i++) begin
        taps_window[i * 3]     = taps_window[i * 3 + 1];
        taps_window[i * 3 + 1] = taps_window[i * 3 + 2];
      end
      taps_window[2] = top;
      taps_window[5] = mid;
      taps_window[8] = px;
      if (started && in_col != 0) begin
        res  = sharpen_pixel(0, 1, 2, w, h);
        have = 1'b1;
      end
      if (have) begin
        expected_pixels.push_back(res);
        if (res.frame_end) begin
          restart_frame();
          return;
        end
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(out_beat_t got);
      out_beat_t want;
      pixels_checked++;
      if (got.frame_end === 1'b1) frames_seen++;
      if (expected_pixels.size() == 0) begin
        $error("output beat with no pending pixel: %h", got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("alpha_out", want.alpha_out, got.alpha_out);
      compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
    endfunction
  endclass

endpackage

FILE: tb/sv/sharpen_3x3_convolution_tb.sv
// sharpen_3x3_convolution_tb: self-checking bench for the 3x3 RGBA sharpen filter.
// Depends on shrp_pkg, sharpen_scoreboard_pkg and the sharpen_3x3_convolution RTL.
module sharpen_3x3_convolution_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shrp_pkg::*;
  import sharpen_scoreboard_pkg::*;

  // The filter pipeline is four stages deep; give it a comfortable margin
  // before touching registers or ending the run.
  localparam int SETTLE_CYCLES   = 12;
  // Long output hold-off: much longer than the pipeline, so the filter fills
  // up and has to stall its input.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BEATS    = 1000;
  // Final stretch of the random part runs with no idling on either side.
  localparam int QUIET_TAIL      = 200;
  localparam int TIMEOUT_NS      = 4_000_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = REG_IMAGE_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_beat_t           out_data_o;

  sharpen_scoreboard sb;
  int gap_odds     = 0;   // chance in ten that the sender pauses before a beat
  int stall_odds   = 0;   // chance in ten that the receiver starts a stall burst
  int random_beats = 0;   // beats of the random part that drive the filter

  sharpen_3x3_convolution DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: check every beat taken and drive the stall. Values read right
  // after the edge are the ones the filter saw at that edge.
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_pixel(out_data_o);
        // Hold off twice while the sender keeps offering beats, so the
        // line pipeline backs up into the input.
        if (sb.pixels_checked == 1 || sb.pixels_checked == 400)
          stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(0, 9) < stall_odds) begin
        stall_left = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------
  // Lean on the channel extremes so saturation at both ends shows up often.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_beat_t pixel_beat(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a);
    in_beat_t beat;
    beat.command  = CMD_PIXEL;
    beat.red_in   = r;
    beat.green_in = g;
    beat.blue_in  = b;
    beat.alpha_in = a;
    return beat;
  endfunction

  function automatic in_beat_t random_pixel();
    return pixel_beat(pick_channel(), pick_channel(), pick_channel(), pick_channel());
  endfunction

  // Flush ticks carry random data; the filter must ignore it.
  function automatic in_beat_t flush_beat();
    in_beat_t beat;
    beat         = random_pixel();
    beat.command = CMD_FLUSH;
    return beat;
  endfunction

  // Mostly small sizes; now and then zero (treated as one) or a larger size.
  function automatic logic [DimW-1:0] pick_dim(int limit);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DimW'($urandom_range(limit + 1, 4 * limit));
      default: return DimW'($urandom_range(1, limit));
    endcase
  endfunction

  // Mostly the legal strength range, sometimes any 12-bit value.
  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return 12'h000;
      3: return 12'($urandom);
      default: return 12'(-int'($urandom_range(16, 1280)));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one beat, optionally after an idle burst, and hold it until taken.
  task automatic send_beat(input in_beat_t beat);
    if (gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    sb.accept_beat(beat);
  endtask

  // Drop valid and wait until every predicted pixel is out and the pipeline
  // has had time to finish beats that release nothing.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the registers selected by mask (bit 0 width, 1 height, 2 weight)
  // once the filter is idle.
  task automatic program_filter(input bit [2:0] mask, input logic [DimW-1:0] width,
                                input logic [DimW-1:0] height,
                                input logic [WeightW-1:0] weight);
    logic [CfgIdxW-1:0]  regs [3];
    logic [CfgDataW-1:0] value [3];
    regs[0]  = REG_IMAGE_WIDTH;
    regs[1]  = REG_IMAGE_HEIGHT;
    regs[2]  = REG_NEIGHBOR_WEIGHT;
    value[0] = width;
    value[1] = height;
    value[2] = {weight[WeightW-1], weight};
    settle();
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= regs[i];
        cfg_data_i <= value[i];
        @(posedge clk_i);
        sb.configure(regs[i], value[i]);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // One frame in raster order followed by the W+1 ticks that drain it. A noisy
  // frame also gets early flushes, pixels among the drain ticks, stray flushes
  // after the end, and now and then is cut short and abandoned.
  task automatic stream_frame(input bit noisy);
    int w;
    int h;
    int cut;
    w   = sb.frame_width();
    h   = sb.frame_height();
    cut = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : w * h;
    for (int n = 0; n < cut; n++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_beat(flush_beat());
      send_beat(random_pixel());
    end
    random_beats += cut;
    if (cut < w * h) return;
    for (int n = 0; n <= w; n++)
      send_beat((noisy && $urandom_range(0, 3) == 0) ? random_pixel() : flush_beat());
    random_beats += w + 1;
    if (noisy && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 2)) send_beat(flush_beat());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    sb.clear();
    gap_odds   = 2;
    stall_odds = 2;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small frame at the strongest legal weight with the channel extremes.
    program_filter(3'b111, 13'd3, 13'd2, -12'sd1280);
    send_beat(flush_beat());                    // nothing to drain yet: ignored
    send_beat(pixel_beat(8'd255, 8'd255, 8'd255, 8'd255));
    send_beat(pixel_beat(8'd0, 8'd0, 8'd0, 8'd0));
    send_beat(pixel_beat(8'd255, 8'd0, 8'd255, 8'd0));
    send_beat(flush_beat());                    // mid-frame flush: ignored
    send_beat(pixel_beat(8'd0, 8'd255, 8'd0, 8'd255));
    send_beat(pixel_beat(8'd255, 8'd255, 8'd255, 8'd255));
    send_beat(pixel_beat(8'd1, 8'd128, 8'd254, 8'd127));
    // Drain four ticks; a pixel in there counts as a tick and its data is lost.
    send_beat(flush_beat());
    send_beat(pixel_beat(8'd77, 8'd200, 8'd3, 8'd90));
    send_beat(flush_beat());
    send_beat(flush_beat());
    send_beat(flush_beat());                    // new frame not filled: ignored

    // Zero width and height behave as 1x1; weakest legal weight.
    program_filter(3'b111, 13'd0, 13'd0, -12'sd16);
    send_beat(random_pixel());
    send_beat(flush_beat());
    send_beat(random_pixel());                  // stands in for the second tick

    // Random part: new sizes and weights, or a weight change that keeps the
    // frame position, each followed by a few frames of random content.
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      if (random_beats >= RANDOM_BEATS - QUIET_TAIL) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(0, 3);
        stall_odds = $urandom_range(0, 3);
      end
      program_filter(($urandom_range(0, 3) == 0) ? 3'b100 : 3'b111,
                     pick_dim(12), pick_dim(6), pick_weight());
      repeat ($urandom_range(1, 3)) stream_frame(1'b1);
    end

    settle();
    $display("Fed %0d beats over small frames, 1x1 sizes, stray flushes and cut frames,",
             sb.beats_noted);
    $display("checking %0d sharpened pixels in %0d completed frames.",
             sb.pixels_checked, sb.frames_seen);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
